/* sv/rfb_pkg.sv */
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types and constants of the RPC frame builder: field phases, frame
// byte positions and the set of values the byte selector reads.
// ----------------------------------------------------------------------------
package rfb_pkg;

   // Largest accepted data field length in bytes.
   localparam logic [23:0] MAX_BODY = 24'd65535;

   // Fixed frame overhead: start, total length, three length words, error
   // code, checksum word and end byte.
   localparam logic [16:0] FRAME_OVERHEAD = 17'd26;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ID,
      PH_METHOD,
      PH_INFO,
      PH_BODY
   } phase_type;

   // Positions in the frame template. Each emitted word has four byte
   // positions, most significant byte first.
   typedef logic [5:0] pos_type;

   localparam pos_type POS_START      = 6'd0;
   localparam pos_type POS_TOTAL0     = 6'd1;
   localparam pos_type POS_IDLEN0     = 6'd5;
   localparam pos_type POS_IDLEN_LAST = 6'd8;
   localparam pos_type POS_DEFID0     = 6'd9;
   localparam pos_type POS_DEFID_LAST = 6'd17;
   localparam pos_type POS_MLEN0      = 6'd18;
   localparam pos_type POS_MLEN_LAST  = 6'd21;
   localparam pos_type POS_ERR0       = 6'd22;
   localparam pos_type POS_ILEN0      = 6'd26;
   localparam pos_type POS_ILEN_LAST  = 6'd29;
   localparam pos_type POS_CHECK0     = 6'd30;
   localparam pos_type POS_END        = 6'd34;
   localparam pos_type POS_DATA       = 6'd35;
   localparam pos_type POS_MISUSE     = 6'd36;
   localparam pos_type POS_STOP       = 6'd63;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_END_BYTE   = 2'd1;
   localparam logic [1:0] CSR_CHECK_WORD = 2'd2;

   // Default message id used when the header gives an empty id.
   localparam logic [7:0] DEFAULT_ID [0:8] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
   };

   // Everything the byte selector needs to form any frame byte.
   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [31:0] check_word;
      logic [16:0] total_len;
      logic [7:0]  id_len;
      logic [8:0]  method_len;
      logic [8:0]  info_len;
      logic [31:0] err_value;
      logic [7:0]  data_byte;
   } frame_fields_type;

endpackage

/* sv/rfb_byte_sel.sv */
// ----------------------------------------------------------------------------
// rfb_byte_sel
// Forms the frame byte at a template position: markers, big-endian words,
// default id characters or the payload data byte.
// ----------------------------------------------------------------------------
module rfb_byte_sel
   import rfb_pkg::*;
(
   input  pos_type          pos,
   input  frame_fields_type fields,
   output logic [7:0]       byte_out
);

   logic [31:0] word;
   logic [5:0]  lane_off;
   logic [5:0]  id_off;

   always_comb begin
      word = '0;
      if (pos >= POS_TOTAL0 && pos < POS_IDLEN0) begin
         word = {15'd0, fields.total_len};
      end else if (pos >= POS_IDLEN0 && pos <= POS_IDLEN_LAST) begin
         word = {24'd0, fields.id_len};
      end else if (pos >= POS_MLEN0 && pos <= POS_MLEN_LAST) begin
         word = {23'd0, fields.method_len};
      end else if (pos >= POS_ERR0 && pos < POS_ILEN0) begin
         word = fields.err_value;
      end else if (pos >= POS_ILEN0 && pos <= POS_ILEN_LAST) begin
         word = {23'd0, fields.info_len};
      end else if (pos >= POS_CHECK0 && pos < POS_END) begin
         word = fields.check_word;
      end
   end

   // Words before the default id start at position 1, the rest at position
   // 18, so the byte lane is the position offset modulo four.
   assign lane_off = (pos < POS_DEFID0) ? (pos - POS_TOTAL0) : (pos - POS_MLEN0);
   assign id_off   = pos - POS_DEFID0;

   always_comb begin
      if (pos == POS_START) begin
         byte_out = fields.start_byte;
      end else if (pos == POS_END) begin
         byte_out = fields.end_byte;
      end else if (pos == POS_DATA) begin
         byte_out = fields.data_byte;
      end else if (pos == POS_MISUSE || pos == POS_STOP) begin
         byte_out = 8'd0;
      end else if (pos >= POS_DEFID0 && pos <= POS_DEFID_LAST) begin
         byte_out = DEFAULT_ID[id_off[3:0]];
      end else begin
         case (lane_off[1:0])
            2'd0:    byte_out = word[31:24];
            2'd1:    byte_out = word[23:16];
            2'd2:    byte_out = word[15:8];
            default: byte_out = word[7:0];
         endcase
      end
   end

endmodule

/* sv/rpc_frame_builder.sv */
// ----------------------------------------------------------------------------
// rpc_frame_builder
// Serializes one RPC message (header item plus payload bytes) into a framed,
// big-endian byte stream with start marker, lengths, checksum and end marker.
// ----------------------------------------------------------------------------
// A request item is taken into the job register; each frame byte it yields is
// then formed and loaded into the output register. Throughput: one frame byte
// per cycle while the output is not stalled. An item holds the input until its
// last byte is emitted: a plain payload byte or a dropped item yields one byte,
// a header nine, a header with an empty id up to 35, a payload byte that ends a
// field up to 18. The single byte sequencer forms the bytes one at a time.
// Reset: markers return to 2 and 3, the checksum word to 1, the block is idle.
module rpc_frame_builder
   import rfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [7:0]         req_id_len,
   input  logic [8:0]         req_method_len,
   input  logic [8:0]         req_info_len,
   input  logic [15:0]        req_body_len,
   input  logic signed [31:0] req_err_value,
   input  logic [7:0]         req_data_byte,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_last,
   output logic               rsp_misuse,

   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // Result of finishing a field: the next non-empty field and its length.
   typedef struct packed {
      phase_type   phase;
      logic [15:0] left;
   } field_state_type;

   // Walks forward from the given field, skipping empty ones. An idle start
   // means that no field is left.
   function automatic field_state_type next_field(input phase_type first,
                                                  input logic [8:0] ml,
                                                  input logic [8:0] il,
                                                  input logic [15:0] bl);
      field_state_type r;
      r.phase = PH_IDLE;
      r.left  = '0;
      if (first == PH_METHOD && ml != 9'd0) begin
         r.phase = PH_METHOD;
         r.left  = {7'd0, ml};
      end else if ((first == PH_METHOD || first == PH_INFO) && il != 9'd0) begin
         r.phase = PH_INFO;
         r.left  = {7'd0, il};
      end else if ((first == PH_METHOD || first == PH_INFO || first == PH_BODY) &&
                   bl != 16'd0) begin
         r.phase = PH_BODY;
         r.left  = bl;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [7:0]  start_byte_ff, end_byte_ff;
   logic [31:0] check_word_ff;

   // Message state.
   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [8:0]  saved_method_len_ff;
   logic [8:0]  saved_info_len_ff;
   logic [15:0] saved_body_len_ff;
   logic [31:0] saved_err_ff;
   logic [7:0]  saved_id_len_ff;
   logic        default_id_ff;
   logic [16:0] total_ff;

   // Byte sequencer: the job in progress and where it stands in the template.
   logic        job_active_ff, job_active_in;
   pos_type     pos_ff, pos_in;
   pos_type     job_next_ff, job_next_in;
   logic [7:0]  job_data_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_out_byte_ff;
   logic        rsp_frame_last_ff;
   logic        rsp_misuse_ff;

   logic             out_adv, emit, last_step, accept;
   logic             hdr_good, pay_good, bad_item;
   logic [7:0]       idl_eff;
   logic [15:0]      left_dec;
   pos_type          step_next;
   field_state_type  hdr_tail, pay_tail;
   phase_type        pay_from;
   frame_fields_type fields;
   logic [7:0]       sel_byte;

   // ---------------------------------------------------------------------
   // Handshake. The output register advances when it is empty or being
   // taken. A new item enters when no job runs, or in the cycle in which
   // the running job hands over its final word.
   // ---------------------------------------------------------------------
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign emit      = job_active_ff && out_adv;
   assign last_step = (step_next == POS_STOP);
   assign req_ready = !job_active_ff || (emit && last_step);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Item classification against the current message state. A header is
   // only good while idle and with an allowed data length; a payload word
   // only while a field still expects bytes.
   // ---------------------------------------------------------------------
   assign hdr_good = (req_kind == 1'b0) && (phase_ff == PH_IDLE) &&
                     ({8'd0, req_body_len} <= MAX_BODY);
   assign pay_good = (req_kind == 1'b1) && (phase_ff != PH_IDLE) &&
                     (bytes_left_ff != 16'd0);
   assign bad_item = !hdr_good && !pay_good;

   assign idl_eff  = (req_id_len == 8'd0) ? 8'd9 : req_id_len;
   assign left_dec = bytes_left_ff - 16'd1;

   // With an empty id the whole default id is emitted with the header, so the
   // message state moves straight on to the first non-empty field from method on.
   assign hdr_tail = next_field(PH_METHOD, req_method_len, req_info_len, req_body_len);

   always_comb begin
      case (phase_ff)
         PH_ID:     pay_from = PH_METHOD;
         PH_METHOD: pay_from = PH_INFO;
         PH_INFO:   pay_from = PH_BODY;
         default:   pay_from = PH_IDLE;
      endcase
   end

   assign pay_tail = next_field(pay_from, saved_method_len_ff, saved_info_len_ff,
                                saved_body_len_ff);

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      if (accept && hdr_good) begin
         if (req_id_len == 8'd0) begin
            phase_in      = hdr_tail.phase;
            bytes_left_in = hdr_tail.left;
         end else begin
            phase_in      = PH_ID;
            bytes_left_in = {8'd0, req_id_len};
         end
      end else if (accept && pay_good) begin
         if (left_dec != 16'd0) begin
            bytes_left_in = left_dec;
         end else begin
            phase_in      = pay_tail.phase;
            bytes_left_in = pay_tail.left;
         end
      end
   end

   // Where the template resumes after a payload byte: nothing more while the
   // field is open, otherwise the fixed words that follow the finished field.
   always_comb begin
      job_next_in = POS_STOP;
      if (left_dec == 16'd0) begin
         case (phase_ff)
            PH_ID:     job_next_in = POS_MLEN0;
            PH_METHOD: job_next_in = POS_ERR0;
            PH_INFO:   job_next_in = (saved_body_len_ff != 16'd0) ? POS_STOP
                                                                  : POS_CHECK0;
            PH_BODY:   job_next_in = POS_CHECK0;
            default:   job_next_in = POS_STOP;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Template walk. The sequence stops where the next field's bytes must
   // come from the input: after the id length unless the default id is
   // used, after the method length if a method follows, and after the
   // info length if info or data bytes follow.
   // ---------------------------------------------------------------------
   always_comb begin
      case (pos_ff)
         POS_IDLEN_LAST: step_next = default_id_ff ? POS_DEFID0 : POS_STOP;
         POS_MLEN_LAST:  step_next = (saved_method_len_ff != 9'd0) ? POS_STOP
                                                                   : POS_ERR0;
         POS_ILEN_LAST:  step_next = (saved_info_len_ff != 9'd0 ||
                                      saved_body_len_ff != 16'd0) ? POS_STOP
                                                                  : POS_CHECK0;
         POS_END:        step_next = POS_STOP;
         POS_DATA:       step_next = job_next_ff;
         POS_MISUSE:     step_next = POS_STOP;
         POS_STOP:       step_next = POS_STOP;
         default:        step_next = pos_ff + 6'd1;
      endcase
   end

   always_comb begin
      job_active_in = job_active_ff;
      pos_in        = pos_ff;
      if (accept) begin
         job_active_in = 1'b1;
         if (bad_item) begin
            pos_in = POS_MISUSE;
         end else if (hdr_good) begin
            pos_in = POS_START;
         end else begin
            pos_in = POS_DATA;
         end
      end else if (emit) begin
         if (last_step) begin
            job_active_in = 1'b0;
         end else begin
            pos_in = step_next;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Byte formation.
   // ---------------------------------------------------------------------
   always_comb begin
      fields.start_byte = start_byte_ff;
      fields.end_byte   = end_byte_ff;
      fields.check_word = check_word_ff;
      fields.total_len  = total_ff;
      fields.id_len     = saved_id_len_ff;
      fields.method_len = saved_method_len_ff;
      fields.info_len   = saved_info_len_ff;
      fields.err_value  = saved_err_ff;
      fields.data_byte  = job_data_ff;
   end

   rfb_byte_sel u_byte_sel (
      .pos      (pos_ff),
      .fields   (fields),
      .byte_out (sel_byte)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff       <= 8'd2;
         end_byte_ff         <= 8'd3;
         check_word_ff       <= 32'd1;
         phase_ff            <= PH_IDLE;
         bytes_left_ff       <= '0;
         saved_method_len_ff <= '0;
         saved_info_len_ff   <= '0;
         saved_body_len_ff   <= '0;
         saved_err_ff        <= '0;
         job_active_ff       <= 1'b0;
         pos_ff              <= POS_STOP;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_START_BYTE: start_byte_ff <= csr_wdata[7:0];
               CSR_END_BYTE:   end_byte_ff   <= csr_wdata[7:0];
               CSR_CHECK_WORD: check_word_ff <= csr_wdata;
               default:        ;
            endcase
         end
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         if (accept && hdr_good) begin
            saved_method_len_ff <= req_method_len;
            saved_info_len_ff   <= req_info_len;
            saved_body_len_ff   <= req_body_len;
            saved_err_ff        <= req_err_value;
         end
         job_active_ff <= job_active_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hdr_good) begin
         saved_id_len_ff <= idl_eff;
         default_id_ff   <= (req_id_len == 8'd0);
         total_ff        <= FRAME_OVERHEAD + {9'd0, idl_eff} + {8'd0, req_method_len} +
                            {8'd0, req_info_len} + {1'b0, req_body_len};
      end
      if (accept) begin
         job_next_ff <= job_next_in;
         job_data_ff <= req_data_byte;
      end
      if (emit) begin
         rsp_out_byte_ff   <= sel_byte;
         rsp_frame_last_ff <= (pos_ff == POS_END);
         rsp_misuse_ff     <= (pos_ff == POS_MISUSE);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_frame_last = rsp_frame_last_ff;
   assign rsp_misuse     = rsp_misuse_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_no_stop_job: assert property (@(posedge clock) disable iff (reset)
      !(job_active_ff && pos_ff == POS_STOP))
      else $error("running job sits at the stop position");

   a_end_when_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && pos_ff == POS_END) |-> (phase_ff == PH_IDLE))
      else $error("end marker emitted while a field is still open");

   a_misuse_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_misuse) |-> (!rsp_frame_last && rsp_out_byte == 8'd0))
      else $error("dropped item word carries frame data");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("emitted word did not reach the output register");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// RPC frame builder testbench
// Sends header and payload words to the frame builder, works out every frame
// byte the block should emit from a model of its own, and compares each byte
// that leaves the block with the oldest byte still due. Both channels idle and
// stall at random; the marker and checksum registers change between phases.
// ----------------------------------------------------------------------------
module testbench
   import rfb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Word kinds on the request channel.
   typedef enum logic {
      KIND_HEADER  = 1'b0,
      KIND_PAYLOAD = 1'b1
   } word_kind_type;

   // Index 3 has no register behind it; writes there must change nothing.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Which field has just been completed when the fixed bytes that follow it
   // are emitted.
   typedef enum logic [1:0] {
      DONE_ID,
      DONE_METHOD,
      DONE_INFO,
      DONE_BODY
   } field_done_type;

   // One request word as it is driven onto the ports.
   typedef struct {
      word_kind_type kind;
      logic [7:0]    id_len;
      logic [8:0]    method_len;
      logic [8:0]    info_len;
      logic [15:0]   body_len;
      logic [31:0]   err_value;
      logic [7:0]    data_byte;
   } msg_word_type;

   // One frame byte as it should leave the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
      logic       misuse;
   } frame_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = 1'b0;
   logic [7:0]         req_id_len = '0;
   logic [8:0]         req_method_len = '0;
   logic [8:0]         req_info_len = '0;
   logic [15:0]        req_body_len = '0;
   logic signed [31:0] req_err_value = '0;
   logic [7:0]         req_data_byte = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_frame_last;
   logic               rsp_misuse;

   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // Words waiting to be sent, and the frame bytes the block still owes us.
   msg_word_type   msg_words[$];
   frame_byte_type frame_due[$];
   msg_word_type   in_flight;

   int unsigned    words_queued = 0;
   int unsigned    mismatches = 0;

   // When set, neither side idles; used for one long stretch of full rate.
   logic           steady_flow = 1'b0;

   // Our own copy of the registers and of the framing state.
   logic [7:0]     mark_start = 8'd2;
   logic [7:0]     mark_end = 8'd3;
   logic [31:0]    check_value = 32'd1;
   phase_type      field_phase = PH_IDLE;
   logic [16:0]    field_left = '0;
   logic [8:0]     held_method_len = '0;
   logic [8:0]     held_info_len = '0;
   logic [15:0]    held_body_len = '0;
   logic [31:0]    held_err = '0;

   rpc_frame_builder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_id_len     (req_id_len),
      .req_method_len (req_method_len),
      .req_info_len   (req_info_len),
      .req_body_len   (req_body_len),
      .req_err_value  (req_err_value),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_misuse     (rsp_misuse),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame prediction
   // ------------------------------------------------------------------------

   function automatic void owe_byte(logic [7:0] value, logic last, logic bad);
      frame_byte_type entry;
      entry.out_byte   = value;
      entry.frame_last = last;
      entry.misuse     = bad;
      frame_due.insert(frame_due.size(), entry);
   endfunction

   // Multi-byte words go out most significant byte first.
   function automatic void owe_word(logic [31:0] value);
      for (int k = 3; k >= 0; k--) owe_byte(value[8*k +: 8], 1'b0, 1'b0);
   endfunction

   // Fixed bytes after a completed field. Empty fields are skipped at once, so
   // one call may run all the way to the end marker.
   function automatic void close_field(field_done_type done_at);
      if (done_at <= DONE_ID) begin
         owe_word(32'(held_method_len));
         if (held_method_len != 0) begin
            field_phase = PH_METHOD;
            field_left  = 17'(held_method_len);
            return;
         end
      end
      if (done_at <= DONE_METHOD) begin
         owe_word(held_err);
         owe_word(32'(held_info_len));
         if (held_info_len != 0) begin
            field_phase = PH_INFO;
            field_left  = 17'(held_info_len);
            return;
         end
      end
      if (done_at <= DONE_INFO) begin
         if (held_body_len != 0) begin
            field_phase = PH_BODY;
            field_left  = 17'(held_body_len);
            return;
         end
      end
      owe_word(check_value);
      owe_byte(mark_end, 1'b1, 1'b0);
      field_phase = PH_IDLE;
      field_left  = '0;
   endfunction

   // Works out every frame byte that one accepted word causes.
   function automatic void serialize_word(msg_word_type w);
      logic [7:0]  id_bytes;
      logic [31:0] total;
      if (w.kind == KIND_HEADER) begin
         // A header in the middle of a frame, or one with too long a data
         // field, is dropped with a single flagged byte.
         if (field_phase != PH_IDLE || 24'(w.body_len) > MAX_BODY) begin
            owe_byte(8'h00, 1'b0, 1'b1);
            return;
         end
         held_method_len = w.method_len;
         held_info_len   = w.info_len;
         held_body_len   = w.body_len;
         held_err        = w.err_value;
         id_bytes = (w.id_len == 0) ? 8'd9 : w.id_len;
         total = 32'd26 + 32'(id_bytes) + 32'(w.method_len) + 32'(w.info_len)
               + 32'(w.body_len);
         owe_byte(mark_start, 1'b0, 1'b0);
         owe_word(total);
         owe_word(32'(id_bytes));
         if (w.id_len == 0) begin
            // The default id is the ASCII digits one through nine.
            for (int k = 0; k < 9; k++) owe_byte(8'h31 + 8'(k), 1'b0, 1'b0);
            close_field(DONE_ID);
         end else begin
            field_phase = PH_ID;
            field_left  = 17'(w.id_len);
         end
         return;
      end
      if (field_phase == PH_IDLE || field_left == 0) begin
         owe_byte(8'h00, 1'b0, 1'b1);
         return;
      end
      owe_byte(w.data_byte, 1'b0, 1'b0);
      field_left = field_left - 1'b1;
      if (field_left == 0) begin
         case (field_phase)
            PH_ID: begin
               close_field(DONE_ID);
            end
            PH_METHOD: begin
               close_field(DONE_METHOD);
            end
            PH_INFO: begin
               close_field(DONE_INFO);
            end
            default: begin
               close_field(DONE_BODY);
            end
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: presents one word at a time from msg_words. The frame
   // bytes a word causes are predicted at the edge where it is accepted, so
   // register writes and state always line up with the block.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) serialize_word(in_flight);
         // A new word may go out only when nothing is held on the port.
         if (!req_valid || req_ready) begin
            if (msg_words.size() != 0 && (steady_flow || $urandom_range(99) >= 20)) begin
               in_flight = msg_words.pop_front();
               req_valid      <= 1'b1;
               req_kind       <= in_flight.kind;
               req_id_len     <= in_flight.id_len;
               req_method_len <= in_flight.method_len;
               req_info_len   <= in_flight.info_len;
               req_body_len   <= in_flight.body_len;
               req_err_value  <= in_flight.err_value;
               req_data_byte  <= in_flight.data_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: stalls at random and checks every accepted byte
   // against the oldest one due.
   // ------------------------------------------------------------------------
   task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      frame_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_due.size() == 0) begin
               log_mismatch("unexpected byte", 32'(rsp_out_byte), 32'h0);
            end else begin
               want = frame_due.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  log_mismatch("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
               if (rsp_frame_last !== want.frame_last)
                  log_mismatch("frame_last", 32'(rsp_frame_last), 32'(want.frame_last));
               if (rsp_misuse !== want.misuse)
                  log_mismatch("misuse", 32'(rsp_misuse), 32'(want.misuse));
            end
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= 20);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void add_word(msg_word_type w);
      msg_words.insert(msg_words.size(), w);
      words_queued++;
   endfunction

   // Fields a word does not use get random values; the block must ignore them.
   function automatic msg_word_type make_header(logic [7:0] id_len, logic [8:0] method_len,
                                                logic [8:0] info_len, logic [15:0] body_len,
                                                logic [31:0] err_value);
      msg_word_type w;
      w.kind       = KIND_HEADER;
      w.id_len     = id_len;
      w.method_len = method_len;
      w.info_len   = info_len;
      w.body_len   = body_len;
      w.err_value  = err_value;
      w.data_byte  = 8'($urandom);
      return w;
   endfunction

   function automatic msg_word_type make_payload(logic [7:0] data_byte);
      msg_word_type w;
      w = make_header(8'($urandom), 9'($urandom), 9'($urandom), 16'($urandom), $urandom);
      w.kind      = KIND_PAYLOAD;
      w.data_byte = data_byte;
      return w;
   endfunction

   // A whole message: the header, then one payload word per field byte.
   // With noise_pct above zero, stray headers land in the middle of the frame;
   // they must be flagged and leave the frame untouched.
   function automatic void queue_frame(logic [7:0] id_len, logic [8:0] method_len,
                                       logic [8:0] info_len, logic [15:0] body_len,
                                       logic [31:0] err_value, int unsigned noise_pct);
      int unsigned count;
      count = int'(id_len) + int'(method_len) + int'(info_len) + int'(body_len);
      add_word(make_header(id_len, method_len, info_len, body_len, err_value));
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(99) < noise_pct)
            add_word(make_header(8'($urandom), 9'($urandom), 9'($urandom),
                                 16'($urandom), $urandom));
         add_word(make_payload(8'($urandom)));
      end
   endfunction

   // Mostly small well-formed messages with random content; empty fields and
   // the default id come up often. A stray payload word between messages
   // stands for a sender that lost track of the frame.
   function automatic void fill_random(int unsigned target);
      int unsigned first;
      first = words_queued;
      while (words_queued - first < target) begin
         if ($urandom_range(99) < 10) add_word(make_payload(8'($urandom)));
         queue_frame(($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(6, 1)),
                     ($urandom_range(99) < 30) ? 9'd0 : 9'($urandom_range(5, 1)),
                     ($urandom_range(99) < 40) ? 9'd0 : 9'($urandom_range(4, 1)),
                     ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom_range(8, 1)),
                     $urandom, 8);
      end
   endfunction

   // Waits until every word has gone out and every frame byte has arrived,
   // then lets the clock run on in case the block is still busy.
   task automatic settle();
      while (msg_words.size() != 0 || req_valid || frame_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle, so the model takes
   // the new value at once.
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      case (index)
         CSR_START_BYTE: begin
            mark_start = value[7:0];
         end
         CSR_END_BYTE: begin
            mark_end = value[7:0];
         end
         CSR_CHECK_WORD: begin
            check_value = value;
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed messages under the reset register values. First a payload
      // word while idle, then a message made of fixed bytes only (default id,
      // all other fields empty), which is the longest burst one word causes.
      add_word(make_payload(8'hFF));
      queue_frame(8'd0, 9'd0, 9'd0, 16'd0, 32'h8000_0000, 0);
      // One byte in every field, with a header arriving mid-frame that
      // carries the largest value of every length field.
      add_word(make_header(8'd1, 9'd1, 9'd1, 16'd1, 32'hFFFF_FFFF));
      add_word(make_payload(8'h00));
      add_word(make_header(8'hFF, 9'h1FF, 9'h1FF, 16'hFFFF, 32'h7FFF_FFFF));
      add_word(make_payload(8'hFF));
      add_word(make_payload(8'hA5));
      add_word(make_payload(8'h5A));
      // Default id followed by a method, then frames where besides the id only
      // the info or only the data field holds bytes.
      queue_frame(8'd0, 9'd2, 9'd0, 16'd0, 32'h0000_0000, 0);
      queue_frame(8'd2, 9'd0, 9'd3, 16'd0, 32'h1234_5678, 0);
      queue_frame(8'd1, 9'd0, 9'd0, 16'd2, 32'h0000_0001, 0);
      add_word(make_payload(8'h00));
      settle();

      // Markers at opposite extremes, every checksum bit set, and a write to
      // the unused index. Upper data bits of byte registers must be ignored.
      write_register(CSR_START_BYTE, {24'($urandom), 8'h00});
      write_register(CSR_END_BYTE, {24'($urandom), 8'hFF});
      write_register(CSR_CHECK_WORD, 32'hFFFF_FFFF);
      write_register(CSR_UNUSED, $urandom);
      fill_random(100);
      settle();

      // The other extremes, with both sides running at full rate.
      write_register(CSR_START_BYTE, {24'($urandom), 8'hFF});
      write_register(CSR_END_BYTE, {24'($urandom), 8'h00});
      write_register(CSR_CHECK_WORD, 32'h0000_0000);
      steady_flow <= 1'b1;
      fill_random(100);
      settle();
      steady_flow <= 1'b0;

      // One longer message with bytes in every field.
      write_register(CSR_START_BYTE, 32'h0000_007E);
      write_register(CSR_END_BYTE, 32'h0000_0081);
      write_register(CSR_CHECK_WORD, $urandom);
      queue_frame(8'd12, 9'd10, 9'd8, 16'd10, $urandom, 0);
      settle();

      write_register(CSR_CHECK_WORD, $urandom);
      fill_random(30);
      settle();

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Safety net in case the block stops answering.
   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
